/* hw/rtl/assert_macros.svh */
// Assertion helpers used by deas_datapath; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* hw/rtl/deas_pkg.sv */
package deas_pkg;

    // Ring capacity; a power of two so ring positions wrap by truncation.
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    localparam int OP_W  = 4;
    localparam int IDX_W = 8;
    localparam int VAL_W = 32;
    localparam int RES_W = 40;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd3;
    localparam logic [OP_W-1:0] OP_GET        = 4'd4;
    localparam logic [OP_W-1:0] OP_SET        = 4'd5;
    localparam logic [OP_W-1:0] OP_MIN        = 4'd6;
    localparam logic [OP_W-1:0] OP_MAX        = 4'd7;
    localparam logic [OP_W-1:0] OP_SUM        = 4'd8;
    localparam logic [OP_W-1:0] OP_MEAN       = 4'd9;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic            load;
        logic            push_back;
        logic            push_front;
        logic            pop_back;
        logic            pop_front;
        logic            get;
        logic            set;
        logic            take_rd;
        logic            walk_start;
        logic            walk;
        logic            take_acc;
        logic            div_start;
        logic            take_div;
        logic            set_status;
        logic [ST_W-1:0] status;
        logic            emit;
    } deas_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            idx_over_cap;
        logic            idx_in_range;
        logic            walk_busy;
        logic            div_done;
        logic            out_free;
    } deas_stat_t;

endpackage

/* hw/rtl/double_ended_array_store.sv */
// One request at a time. Push, set and rejected requests pass through execute and done;
// pop, and get of an index in range, add a store read; min, max and sum walk the store
// (one store read per element), and mean then runs the 40-step divider on the total.
// A new request is taken as soon as the previous result sits in the output register.
// Reset (rst_n low, asynchronous) empties the ring: head, count and all slot valid
// bits clear at once, so every slot reads as zero with no clearing pass.
module double_ended_array_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // index[7:0], value[39:8]
    input  logic [3:0]  s_tuser,  // op[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // result[39:0], size[48:40], zero[55:49]
    output logic [1:0]  m_tuser   // status[1:0]
);

    deas_pkg::deas_cmd_t  cmd;
    deas_pkg::deas_stat_t stat;

    logic [deas_pkg::RES_W-1:0]   result;
    logic [deas_pkg::COUNT_W-1:0] size;

    deas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    deas_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_index   (s_tdata[7:0]),
        .in_value   (s_tdata[39:8]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .out_status (m_tuser),
        .out_size   (size)
    );

    assign m_tdata = {7'd0, size, result};

endmodule

/* hw/rtl/deas_ram.sv */
module deas_ram #(
    parameter int WIDTH = deas_pkg::VAL_W,
    parameter int DEPTH = deas_pkg::CAPACITY
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/deas_div.sv */
module deas_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [deas_pkg::RES_W-1:0]   dividend,
    input  logic [deas_pkg::COUNT_W-1:0] divisor,
    output logic                         done,
    output logic [deas_pkg::RES_W-1:0]   quotient
);

    localparam int DW  = deas_pkg::RES_W;
    localparam int VW  = deas_pkg::COUNT_W;
    localparam int CW  = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic          neg_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;

    logic [DW-1:0] mag;
    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_sub;
    logic          fits;

    assign mag     = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
    assign rem_sh  = {rem_reg, quo_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign fits    = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(DW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // one quotient bit per cycle on the magnitude
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[DW-1];
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                rem_reg <= rem_sub[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

/* hw/rtl/deas_datapath.sv */
`include "assert_macros.svh"

module deas_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  deas_pkg::deas_cmd_t           cmd,
    output deas_pkg::deas_stat_t          stat,
    input  logic [deas_pkg::OP_W-1:0]     in_op,
    input  logic [deas_pkg::IDX_W-1:0]    in_index,
    input  logic [deas_pkg::VAL_W-1:0]    in_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [deas_pkg::RES_W-1:0]    out_result,
    output logic [deas_pkg::ST_W-1:0]     out_status,
    output logic [deas_pkg::COUNT_W-1:0]  out_size
);

    localparam int AW = deas_pkg::ADDR_W;
    localparam int NW = deas_pkg::COUNT_W;
    localparam int VW = deas_pkg::VAL_W;
    localparam int RW = deas_pkg::RES_W;
    localparam logic [NW-1:0] CAP_COUNT = NW'(deas_pkg::CAPACITY);

    logic [deas_pkg::OP_W-1:0]  op_reg;
    logic [deas_pkg::IDX_W-1:0] index_reg;
    logic [VW-1:0]              value_reg;

    logic [AW-1:0]                 head_reg;
    logic [NW-1:0]                 count_reg;
    logic [deas_pkg::CAPACITY-1:0] valid_reg;
    logic                          rvalid_reg;

    logic [NW-1:0] ptr_reg;
    logic          pend_reg;
    logic          first_reg;
    logic [RW-1:0] acc_reg;

    logic [RW-1:0]             res_reg;
    logic [deas_pkg::ST_W-1:0] st_reg;

    logic                      out_valid_reg;
    logic [RW-1:0]             out_res_reg;
    logic [deas_pkg::ST_W-1:0] out_st_reg;
    logic [NW-1:0]             out_size_reg;

    logic [AW-1:0] slot_back;
    logic [AW-1:0] slot_last;
    logic [AW-1:0] slot_front;
    logic [AW-1:0] slot_index;
    logic [AW-1:0] slot_walk;
    logic [NW-1:0] index_ext;
    logic          walk_more;

    logic          we;
    logic [AW-1:0] waddr;
    logic          re;
    logic [AW-1:0] raddr;
    logic [VW-1:0] rdata;
    logic [VW-1:0] rd_val;
    logic [RW-1:0] rd_ext;
    logic          take_new;

    logic          div_done;
    logic [RW-1:0] div_q;

    assign index_ext  = NW'(index_reg);
    assign slot_back  = head_reg + count_reg[AW-1:0];
    assign slot_last  = slot_back - 1'b1;
    assign slot_front = head_reg - 1'b1;
    assign slot_index = head_reg + AW'(index_reg);
    assign slot_walk  = head_reg + ptr_reg[AW-1:0];
    assign walk_more  = ptr_reg < count_reg;

    assign we = cmd.push_back | cmd.push_front | cmd.set;
    assign re = cmd.pop_back | cmd.pop_front | cmd.get | (cmd.walk & walk_more);

    always_comb
    begin
        priority if (cmd.push_back)
        begin
            waddr = slot_back;
        end
        else if (cmd.push_front)
        begin
            waddr = slot_front;
        end
        else
        begin
            waddr = slot_index;
        end
    end

    always_comb
    begin
        priority if (cmd.pop_back)
        begin
            raddr = slot_last;
        end
        else if (cmd.pop_front)
        begin
            raddr = head_reg;
        end
        else if (cmd.get)
        begin
            raddr = slot_index;
        end
        else
        begin
            raddr = slot_walk;
        end
    end

    deas_ram #(
        .WIDTH (VW),
        .DEPTH (deas_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (value_reg),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // a slot never written since reset or freed by a pop reads as zero
    assign rd_val = rvalid_reg ? rdata : '0;
    assign rd_ext = {{(RW - VW){rd_val[VW-1]}}, rd_val};

    deas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_op;
            index_reg <= in_index;
            value_reg <= in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.pop_back || cmd.pop_front)
            begin
                valid_reg[raddr] <= 1'b0;
            end
            if (cmd.push_front)
            begin
                head_reg <= slot_front;
            end
            else if (cmd.pop_front)
            begin
                head_reg <= head_reg + 1'b1;
            end
            if (cmd.push_back || cmd.push_front)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.pop_back || cmd.pop_front)
            begin
                count_reg <= count_reg - 1'b1;
            end
            else if (cmd.set && !stat.idx_in_range)
            begin
                count_reg <= index_ext + 1'b1;
            end
        end
    end

    // walk pointer runs one read ahead of the accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.walk_start)
        begin
            ptr_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.walk)
        begin
            pend_reg <= walk_more;
            if (walk_more)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (op_reg)
            deas_pkg::OP_MIN:
                take_new = first_reg || ($signed(rd_val) < $signed(acc_reg[VW-1:0]));
            deas_pkg::OP_MAX:
                take_new = first_reg || ($signed(rd_val) > $signed(acc_reg[VW-1:0]));
            default:
                take_new = 1'b0;
        endcase
    end

    // the sum of a full store of 32-bit values fits 40 bits without saturation
    always_ff @(posedge clk)
    begin
        if (cmd.walk_start)
        begin
            acc_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.walk && pend_reg)
        begin
            first_reg <= 1'b0;
            if (op_reg == deas_pkg::OP_MIN || op_reg == deas_pkg::OP_MAX)
            begin
                if (take_new)
                begin
                    acc_reg <= rd_ext;
                end
            end
            else
            begin
                acc_reg <= acc_reg + rd_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_reg <= '0;
            st_reg  <= deas_pkg::ST_OK;
        end
        else
        begin
            if (cmd.set_status)
            begin
                st_reg <= cmd.status;
            end
            priority if (cmd.take_rd)
            begin
                res_reg <= rd_ext;
            end
            else if (cmd.take_acc)
            begin
                res_reg <= acc_reg;
            end
            else if (cmd.take_div)
            begin
                res_reg <= div_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_res_reg  <= res_reg;
            out_st_reg   <= st_reg;
            out_size_reg <= count_reg;
        end
    end

    assign stat.op           = op_reg;
    assign stat.full         = count_reg >= CAP_COUNT;
    assign stat.empty        = count_reg == '0;
    assign stat.idx_over_cap = index_ext >= CAP_COUNT;
    assign stat.idx_in_range = index_ext < count_reg;
    assign stat.walk_busy    = walk_more | pend_reg;
    assign stat.div_done     = div_done;
    assign stat.out_free     = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_result = out_res_reg;
    assign out_status = out_st_reg;
    assign out_size   = out_size_reg;

    `ASSERT_PROP(a_count_bound, clk, rst_n, count_reg <= CAP_COUNT, "count beyond capacity")
    `ASSERT_PROP(a_emit_free, clk, rst_n, cmd.emit |-> (!out_valid_reg || out_ready), "result overwritten")
    `ASSERT_NEVER(a_wr_pop, clk, rst_n, we && (cmd.pop_back || cmd.pop_front), "write during pop")
    `ASSERT_PROP(a_pop_count, clk, rst_n, (cmd.pop_back || cmd.pop_front) |=> (count_reg == $past(count_reg) - 1'b1), "pop did not shrink count")

endmodule

/* hw/rtl/deas_ctrl.sv */
module deas_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  deas_pkg::deas_stat_t stat,
    output deas_pkg::deas_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_WALK,
        S_WALK_END,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (stat.op)
                    deas_pkg::OP_PUSH_BACK, deas_pkg::OP_PUSH_FRONT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = deas_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push_back  = stat.op == deas_pkg::OP_PUSH_BACK;
                            cmd.push_front = stat.op == deas_pkg::OP_PUSH_FRONT;
                        end
                    end
                    deas_pkg::OP_POP_BACK, deas_pkg::OP_POP_FRONT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = deas_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop_back  = stat.op == deas_pkg::OP_POP_BACK;
                            cmd.pop_front = stat.op == deas_pkg::OP_POP_FRONT;
                            state_next    = S_READ;
                        end
                    end
                    deas_pkg::OP_GET:
                    begin
                        if (stat.idx_over_cap)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = deas_pkg::ST_FULL;
                        end
                        else if (stat.idx_in_range)
                        begin
                            cmd.get    = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    deas_pkg::OP_SET:
                    begin
                        if (stat.idx_over_cap)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = deas_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.set = 1'b1;
                        end
                    end
                    deas_pkg::OP_MIN, deas_pkg::OP_MAX, deas_pkg::OP_MEAN:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = deas_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                    deas_pkg::OP_SUM:
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_WALK;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.take_rd = 1'b1;
                state_next  = S_DONE;
            end
            S_WALK:
            begin
                if (stat.walk_busy)
                begin
                    cmd.walk = 1'b1;
                end
                else
                begin
                    state_next = S_WALK_END;
                end
            end
            S_WALK_END:
            begin
                if (stat.op == deas_pkg::OP_MEAN)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.take_acc = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.take_div = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [deas_pkg::OP_W-1:0] OP_SPARE_FIRST = 4'd10;
    localparam logic [deas_pkg::OP_W-1:0] OP_SPARE_LAST  = 4'd15;

    localparam longint SUM_CEIL  = 64'sd549755813887;
    localparam longint SUM_FLOOR = -64'sd549755813888;

    localparam int RANDOM_ITEMS   = 1450;
    localparam int HOLD_OFF_LEN   = 500;
    localparam int DRAIN_CYCLES   = 400;
    localparam int PRINT_LIMIT    = 100;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_mode_t;
    typedef enum {VAL_ANY, VAL_TOP, VAL_BOTTOM, VAL_NARROW} value_mode_t;

    typedef struct packed {
        logic [deas_pkg::RES_W-1:0] result;
        logic [deas_pkg::ST_W-1:0]  status;
        logic [8:0]                 size;
    } deque_result_t;

    typedef struct packed {
        logic [deas_pkg::OP_W-1:0]  op;
        logic [deas_pkg::IDX_W-1:0] idx;
        logic [deas_pkg::VAL_W-1:0] val;
        bit                         typed;
        deque_result_t              want;
    } request_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    // shadow of the ring
    logic signed [deas_pkg::VAL_W-1:0] deque_slots [deas_pkg::CAPACITY];
    int ring_head;
    int ring_count;

    deque_result_t pending_results[$];
    int  mismatches;
    bit  quiet_stretch;
    bit  hold_off_request;

    request_row_t directed_rows [25];

    double_ended_array_store uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic int slot_at(input int pos);
        return (ring_head + pos) % deas_pkg::CAPACITY;
    endfunction

    function automatic longint ring_total();
        longint acc;
        acc = 0;
        for (int i = 0; i < ring_count; i++)
            acc += longint'(deque_slots[slot_at(i)]);
        return acc;
    endfunction

    // apply one request to the shadow ring and work out its result
    task automatic predict_request(input logic [deas_pkg::OP_W-1:0] op,
                                   input logic [deas_pkg::IDX_W-1:0] idx,
                                   input logic signed [deas_pkg::VAL_W-1:0] val,
                                   output deque_result_t want);
        longint acc;
        longint cur;
        int     slot;
        acc = 0;
        want.status = deas_pkg::ST_OK;
        case (op)
            deas_pkg::OP_PUSH_BACK:
                if (ring_count >= deas_pkg::CAPACITY)
                    want.status = deas_pkg::ST_FULL;
                else
                begin
                    deque_slots[slot_at(ring_count)] = val;
                    ring_count++;
                end
            deas_pkg::OP_PUSH_FRONT:
                if (ring_count >= deas_pkg::CAPACITY)
                    want.status = deas_pkg::ST_FULL;
                else
                begin
                    ring_head = (ring_head + deas_pkg::CAPACITY - 1) % deas_pkg::CAPACITY;
                    deque_slots[ring_head] = val;
                    ring_count++;
                end
            deas_pkg::OP_POP_BACK:
                if (ring_count == 0)
                    want.status = deas_pkg::ST_EMPTY;
                else
                begin
                    slot = slot_at(ring_count - 1);
                    acc = longint'(deque_slots[slot]);
                    deque_slots[slot] = '0;
                    ring_count--;
                end
            deas_pkg::OP_POP_FRONT:
                if (ring_count == 0)
                    want.status = deas_pkg::ST_EMPTY;
                else
                begin
                    acc = longint'(deque_slots[ring_head]);
                    deque_slots[ring_head] = '0;
                    ring_head = (ring_head + 1) % deas_pkg::CAPACITY;
                    ring_count--;
                end
            deas_pkg::OP_GET:
                if (int'(idx) >= deas_pkg::CAPACITY)
                    want.status = deas_pkg::ST_FULL;
                else if (int'(idx) < ring_count)
                    acc = longint'(deque_slots[slot_at(idx)]);
            deas_pkg::OP_SET:
                if (int'(idx) >= deas_pkg::CAPACITY)
                    want.status = deas_pkg::ST_FULL;
                else
                begin
                    deque_slots[slot_at(idx)] = val;
                    if (int'(idx) >= ring_count)
                        ring_count = int'(idx) + 1;
                end
            deas_pkg::OP_MIN, deas_pkg::OP_MAX:
                if (ring_count == 0)
                    want.status = deas_pkg::ST_EMPTY;
                else
                begin
                    acc = longint'(deque_slots[ring_head]);
                    for (int i = 1; i < ring_count; i++)
                    begin
                        cur = longint'(deque_slots[slot_at(i)]);
                        if (op == deas_pkg::OP_MIN ? (cur < acc) : (cur > acc))
                            acc = cur;
                    end
                end
            deas_pkg::OP_SUM:
            begin
                acc = ring_total();
                if (acc > SUM_CEIL)
                    acc = SUM_CEIL;
                if (acc < SUM_FLOOR)
                    acc = SUM_FLOOR;
            end
            deas_pkg::OP_MEAN:
                if (ring_count == 0)
                    want.status = deas_pkg::ST_EMPTY;
                else
                    acc = ring_total() / longint'(ring_count);
            default:
                acc = 0;
        endcase
        want.result = acc[deas_pkg::RES_W-1:0];
        want.size   = 9'(ring_count);
    endtask

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_request(input logic [deas_pkg::OP_W-1:0] op,
                                input logic [deas_pkg::IDX_W-1:0] idx,
                                input logic [deas_pkg::VAL_W-1:0] val, input bit typed,
                                input deque_result_t typed_want);
        deque_result_t want;
        if (!quiet_stretch)
            while ($urandom_range(99) < 33)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(op, idx, val, want);
        pending_results.push_back(typed ? typed_want : want);
        @(negedge clk);
    endtask

    function automatic logic [deas_pkg::OP_W-1:0] pick_op(input burst_mode_t mode);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return deas_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        case (mode)
            MODE_FILL:
                if (r < 78)
                    return $urandom_range(1) ? deas_pkg::OP_PUSH_BACK : deas_pkg::OP_PUSH_FRONT;
                else if (r < 84)
                    return deas_pkg::OP_SET;
                else if (r < 88)
                    return deas_pkg::OP_GET;
                else if (r < 95)
                    return deas_pkg::OP_W'($urandom_range(deas_pkg::OP_MIN, deas_pkg::OP_MEAN));
                else
                    return $urandom_range(1) ? deas_pkg::OP_POP_BACK : deas_pkg::OP_POP_FRONT;
            MODE_DRAIN:
                if (r < 78)
                    return $urandom_range(1) ? deas_pkg::OP_POP_BACK : deas_pkg::OP_POP_FRONT;
                else if (r < 84)
                    return deas_pkg::OP_GET;
                else if (r < 92)
                    return deas_pkg::OP_W'($urandom_range(deas_pkg::OP_MIN, deas_pkg::OP_MEAN));
                else if (r < 96)
                    return deas_pkg::OP_SET;
                else
                    return $urandom_range(1) ? deas_pkg::OP_PUSH_BACK : deas_pkg::OP_PUSH_FRONT;
            default:
                return deas_pkg::OP_W'($urandom_range(deas_pkg::OP_PUSH_BACK,
                                                      deas_pkg::OP_MEAN));
        endcase
    endfunction

    function automatic logic [deas_pkg::IDX_W-1:0] pick_index(input burst_mode_t mode,
                                                              input logic [deas_pkg::OP_W-1:0] op);
        int top;
        // keep sets inside the array while draining so it can empty
        if (mode == MODE_DRAIN && op == deas_pkg::OP_SET)
            return (ring_count == 0) ? '0 : deas_pkg::IDX_W'($urandom_range(0, ring_count - 1));
        if ($urandom_range(99) < 70)
        begin
            top = (ring_count + 2 > 255) ? 255 : ring_count + 2;
            return deas_pkg::IDX_W'($urandom_range(0, top));
        end
        return deas_pkg::IDX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [deas_pkg::VAL_W-1:0] pick_value(input value_mode_t vmode);
        case (vmode)
            VAL_TOP:    return 32'h7FFF_FFFF;
            VAL_BOTTOM: return 32'h8000_0000;
            VAL_NARROW: return deas_pkg::VAL_W'(int'($urandom_range(0, 262143)) - 131072);
            default:
                case ($urandom_range(39))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    // receiver: random stalls, a long hold-off on request, none in the quiet stretch
    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_left = HOLD_OFF_LEN;
                hold_off_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (quiet_stretch)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 33);
        end
    end

    always @(posedge clk)
    begin : check_results
        deque_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", longint'(m_tdata), 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[39:0] !== want.result)
                    report_mismatch("result", longint'(m_tdata[39:0]), longint'(want.result));
                if (m_tuser !== want.status)
                    report_mismatch("status", longint'(m_tuser), longint'(want.status));
                if (m_tdata[48:40] !== want.size)
                    report_mismatch("size", longint'(m_tdata[48:40]), longint'(want.size));
            end
        end
    end

    initial
    begin
        burst_mode_t                mode;
        value_mode_t                vmode;
        logic [deas_pkg::OP_W-1:0]  op;
        logic [deas_pkg::IDX_W-1:0] idx;
        logic [deas_pkg::VAL_W-1:0] val;
        int issued;
        int bursts;
        int n;
        int len;
        int tail;
        int extra;
        bit done;

        mismatches = 0;
        quiet_stretch = 1'b0;
        hold_off_request = 1'b0;
        ring_head = 0;
        ring_count = 0;
        for (int i = 0; i < deas_pkg::CAPACITY; i++)
            deque_slots[i] = '0;

        directed_rows = '{
            '{deas_pkg::OP_SUM, 8'd0, 32'h0, 1'b1, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_MIN, 8'd0, 32'h0, 1'b1, '{40'd0, deas_pkg::ST_EMPTY, 9'd0}},
            '{deas_pkg::OP_MAX, 8'd0, 32'h0, 1'b1, '{40'd0, deas_pkg::ST_EMPTY, 9'd0}},
            '{deas_pkg::OP_MEAN, 8'd0, 32'h0, 1'b1, '{40'd0, deas_pkg::ST_EMPTY, 9'd0}},
            '{deas_pkg::OP_POP_BACK, 8'd0, 32'h0, 1'b1, '{40'd0, deas_pkg::ST_EMPTY, 9'd0}},
            '{deas_pkg::OP_POP_FRONT, 8'd0, 32'h0, 1'b1, '{40'd0, deas_pkg::ST_EMPTY, 9'd0}},
            '{deas_pkg::OP_GET, 8'd0, 32'h0, 1'b1, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_GET, 8'd255, 32'hFFFF_FFFF, 1'b1, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{OP_SPARE_FIRST, 8'd0, 32'hFFFF_FFFF, 1'b1, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{OP_SPARE_LAST, 8'd255, 32'hFFFF_FFFF, 1'b1, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_PUSH_BACK, 8'd0, 32'h7FFF_FFFF, 1'b1,
              '{40'd0, deas_pkg::ST_OK, 9'd1}},
            '{deas_pkg::OP_PUSH_FRONT, 8'hAA, 32'h8000_0000, 1'b1,
              '{40'd0, deas_pkg::ST_OK, 9'd2}},
            '{deas_pkg::OP_GET, 8'd0, 32'h0, 1'b0, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_GET, 8'd1, 32'h0, 1'b0, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_MIN, 8'd0, 32'h0, 1'b0, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_MAX, 8'd0, 32'h0, 1'b0, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_SUM, 8'd0, 32'h0, 1'b0, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_MEAN, 8'd0, 32'h0, 1'b0, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_SET, 8'd255, 32'h0001_0000, 1'b1,
              '{40'd0, deas_pkg::ST_OK, 9'd256}},
            '{deas_pkg::OP_PUSH_BACK, 8'd0, 32'h1234_5678, 1'b1,
              '{40'd0, deas_pkg::ST_FULL, 9'd256}},
            '{deas_pkg::OP_PUSH_FRONT, 8'd0, 32'h1234_5678, 1'b1,
              '{40'd0, deas_pkg::ST_FULL, 9'd256}},
            '{deas_pkg::OP_MEAN, 8'd0, 32'h0, 1'b0, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_GET, 8'd200, 32'h0, 1'b0, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_POP_FRONT, 8'd0, 32'h0, 1'b0, '{40'd0, deas_pkg::ST_OK, 9'd0}},
            '{deas_pkg::OP_POP_BACK, 8'd0, 32'h0, 1'b0, '{40'd0, deas_pkg::ST_OK, 9'd0}}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                         directed_rows[i].typed, directed_rows[i].want);

        // bursts: drain to empty, fill to full, or mix; the first two are forced
        issued = 0;
        bursts = 0;
        done = 1'b0;
        while (!done)
        begin
            if (bursts == 0)
                mode = MODE_DRAIN;
            else if (bursts == 1)
                mode = MODE_FILL;
            else
                mode = burst_mode_t'($urandom_range(0, 2));
            case ($urandom_range(9))
                0:       vmode = VAL_TOP;
                1:       vmode = VAL_BOTTOM;
                2, 3:    vmode = VAL_NARROW;
                default: vmode = VAL_ANY;
            endcase
            len = $urandom_range(40, 200);
            extra = $urandom_range(5, 20);
            n = 0;
            tail = 0;
            bursts++;
            while (1)
            begin
                op  = pick_op(mode);
                idx = pick_index(mode, op);
                val = pick_value(vmode);
                if (issued == 500)
                    hold_off_request = 1'b1;
                quiet_stretch = (issued >= 900 && issued < 1100);
                send_request(op, idx, val, 1'b0, '0);
                issued++;
                n++;
                if ((mode == MODE_FILL && ring_count == deas_pkg::CAPACITY) ||
                    (mode == MODE_DRAIN && ring_count == 0))
                    tail++;
                if (issued >= RANDOM_ITEMS)
                begin
                    done = 1'b1;
                    break;
                end
                if (mode == MODE_MIX ? (n >= len) : (tail >= extra || n >= 600))
                    break;
            end
        end
        s_tvalid <= 1'b0;
        quiet_stretch = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* double_ended_array_store.f */
+incdir+hw/rtl
hw/rtl/deas_pkg.sv
hw/rtl/deas_ram.sv
hw/rtl/deas_div.sv
hw/rtl/deas_datapath.sv
hw/rtl/deas_ctrl.sv
hw/rtl/double_ended_array_store.sv
tb/sv/testbench.sv
